[rtl/timer64_compare_irq_macros.svh]
// Assertion macros used by the timer top level.
`ifndef TIMER64_COMPARE_IRQ_MACROS_SVH
`define TIMER64_COMPARE_IRQ_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define T64_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("timer64 check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define T64_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("timer64 check failed");

`endif

[rtl/tmr64_pkg.sv]
// Shared types and constants of the 64-bit compare timer.
`default_nettype none
package tmr64_pkg;

	// Request kinds
	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_WRITE = 2'd2;

	// Register indexes
	localparam logic [4:0] REG_CLC    = 5'd0;
	localparam logic [4:0] REG_ID     = 5'd1;
	localparam logic [4:0] REG_TIM0   = 5'd2;
	localparam logic [4:0] REG_TIM1   = 5'd3;
	localparam logic [4:0] REG_TIM2   = 5'd4;
	localparam logic [4:0] REG_TIM3   = 5'd5;
	localparam logic [4:0] REG_TIM4   = 5'd6;
	localparam logic [4:0] REG_TIM5   = 5'd7;
	localparam logic [4:0] REG_TIM6   = 5'd8;
	localparam logic [4:0] REG_CAP    = 5'd9;
	localparam logic [4:0] REG_CMP0   = 5'd10;
	localparam logic [4:0] REG_CMP1   = 5'd11;
	localparam logic [4:0] REG_CMCON  = 5'd12;
	localparam logic [4:0] REG_ICR    = 5'd13;
	localparam logic [4:0] REG_ISCR   = 5'd14;
	localparam logic [4:0] REG_OCS    = 5'd15;
	localparam logic [4:0] REG_ACCEN0 = 5'd16;
	localparam logic [4:0] REG_ACCEN1 = 5'd17;

	// ICR bit positions
	localparam int IC_EN0 = 0;
	localparam int IC_IR0 = 1;
	localparam int IC_OS0 = 2;
	localparam int IC_EN1 = 4;
	localparam int IC_IR1 = 5;
	localparam int IC_OS1 = 6;
	localparam logic [6:0] ICR_WMASK = 7'b101_0101;

	localparam logic [31:0] MODULE_ID    = 32'h0000_C000;
	localparam logic [31:0] ACCEN_RESET  = 32'hFFFF_FFFF;
	localparam logic [15:0] INC_RESET    = 16'd1;

	typedef struct packed {
		logic [4:0] start;
		logic [4:0] size;
	} window_cfg_t;

endpackage
`default_nettype wire

[rtl/timer64_compare_irq.sv]
// Top level of the 64-bit timer with two masked compare interrupts.
// Usage:
//   Input channel (in_valid/in_ready) carries one request per transfer:
//   a tick, a register read or a register write (req_type, reg_index,
//   write_data). Output channel (out_valid/out_ready) returns one result
//   per request: read_data, access_error and both interrupt flags.
//   The result is registered and shows in the cycle after the input
//   transfer. Throughput: one request per cycle unless the receiver stalls;
//   the counter add, both window compares and the register decode settle
//   combinationally. On a stall the result register holds and in_ready
//   drops; it rises again in the cycle the held result is taken, so a new
//   request can transfer in that same cycle.
//   cfg_we/cfg_wdata write the per-tick increment.
//   Reset: counter, capture, compare, control registers and flags clear,
//   access enables go to all ones, the increment goes to 1, and the
//   output channel is empty.
`default_nettype none
`include "timer64_compare_irq_macros.svh"
module timer64_compare_irq import tmr64_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [4:0]  reg_index,
	input  logic [31:0] write_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] read_data,
	output logic        access_error,
	output logic        irq_compare0,
	output logic        irq_compare1
);

	logic [15:0] inc_q;
	logic [63:0] count_q, count_d, count_sum;
	logic [31:0] cap_q, cap_d;
	logic [31:0] cmp0_q, cmp0_d;
	logic [31:0] cmp1_q, cmp1_d;
	logic [31:0] cmcon_q, cmcon_d;
	logic [6:0]  icr_q, icr_d;
	logic [31:0] clc_q, clc_d;
	logic [31:0] ocs_q, ocs_d;
	logic [31:0] accen0_q, accen0_d;
	logic [31:0] accen1_q, accen1_d;

	logic        out_valid_q;
	logic [31:0] read_data_q, rd_d;
	logic        access_error_q, err_d;
	logic        acc;
	logic        match0, match1;
	window_cfg_t win0, win1;

	assign in_ready = !out_valid_q || out_ready;
	assign acc      = in_valid && in_ready;

	assign count_sum = count_q + {48'b0, inc_q};
	assign win0      = '{start: cmcon_q[12:8], size: cmcon_q[4:0]};
	assign win1      = '{start: cmcon_q[28:24], size: cmcon_q[20:16]};

	tmr64_window_cmp u_cmp0 (
		.count (count_sum),
		.cmp   (cmp0_q),
		.win   (win0),
		.match (match0)
	);

	tmr64_window_cmp u_cmp1 (
		.count (count_sum),
		.cmp   (cmp1_q),
		.win   (win1),
		.match (match1)
	);

	always_comb begin
		count_d  = count_q;
		cap_d    = cap_q;
		cmp0_d   = cmp0_q;
		cmp1_d   = cmp1_q;
		cmcon_d  = cmcon_q;
		icr_d    = icr_q;
		clc_d    = clc_q;
		ocs_d    = ocs_q;
		accen0_d = accen0_q;
		accen1_d = accen1_q;
		rd_d     = 32'b0;
		err_d    = 1'b0;
		case (req_type)
			REQ_TICK: begin
				count_d = count_sum;
				if (icr_q[IC_EN0] && match0) icr_d[IC_IR0] = 1'b1;
				if (icr_q[IC_EN1] && match1) icr_d[IC_IR1] = 1'b1;
			end
			REQ_READ: begin
				// views TIM0..TIM5 snapshot the upper word
				if (reg_index inside {[REG_TIM0:REG_TIM5]}) cap_d = count_q[63:32];
				case (reg_index)
					REG_CLC:    rd_d = clc_q;
					REG_ID:     rd_d = MODULE_ID;
					REG_TIM0:   rd_d = count_q[31:0];
					REG_TIM1:   rd_d = count_q[35:4];
					REG_TIM2:   rd_d = count_q[39:8];
					REG_TIM3:   rd_d = count_q[47:16];
					REG_TIM4:   rd_d = count_q[51:20];
					REG_TIM5:   rd_d = count_q[55:24];
					REG_TIM6:   rd_d = count_q[63:32];
					REG_CAP:    rd_d = cap_q;
					REG_CMP0:   rd_d = cmp0_q;
					REG_CMP1:   rd_d = cmp1_q;
					REG_CMCON:  rd_d = cmcon_q;
					REG_ICR:    rd_d = {25'b0, icr_q};
					REG_OCS:    rd_d = ocs_q;
					REG_ACCEN0: rd_d = accen0_q;
					REG_ACCEN1: rd_d = accen1_q;
					default:    rd_d = 32'b0;
				endcase
			end
			REQ_WRITE: begin
				case (reg_index)
					REG_CLC:    clc_d = write_data;
					REG_CMP0:   cmp0_d = write_data;
					REG_CMP1:   cmp1_d = write_data;
					REG_CMCON:  cmcon_d = write_data;
					// keep the request flags, take enable and one-shot bits
					REG_ICR:    icr_d = (icr_q & ~ICR_WMASK) | (write_data[6:0] & ICR_WMASK);
					REG_ISCR: begin
						// clear before set
						icr_d[IC_IR0] = (icr_q[IC_IR0] & ~write_data[0]) | write_data[1];
						icr_d[IC_IR1] = (icr_q[IC_IR1] & ~write_data[2]) | write_data[3];
					end
					REG_OCS:    ocs_d = write_data;
					REG_ACCEN0: accen0_d = write_data;
					REG_ACCEN1: accen1_d = write_data;
					default:    err_d = 1'b1;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inc_q          <= INC_RESET;
			count_q        <= 64'b0;
			cap_q          <= 32'b0;
			cmp0_q         <= 32'b0;
			cmp1_q         <= 32'b0;
			cmcon_q        <= 32'b0;
			icr_q          <= 7'b0;
			clc_q          <= 32'b0;
			ocs_q          <= 32'b0;
			accen0_q       <= ACCEN_RESET;
			accen1_q       <= ACCEN_RESET;
			out_valid_q    <= 1'b0;
			read_data_q    <= 32'b0;
			access_error_q <= 1'b0;
		end else begin
			if (cfg_we) inc_q <= cfg_wdata;
			if (acc) begin
				count_q        <= count_d;
				cap_q          <= cap_d;
				cmp0_q         <= cmp0_d;
				cmp1_q         <= cmp1_d;
				cmcon_q        <= cmcon_d;
				icr_q          <= icr_d;
				clc_q          <= clc_d;
				ocs_q          <= ocs_d;
				accen0_q       <= accen0_d;
				accen1_q       <= accen1_d;
				read_data_q    <= rd_d;
				access_error_q <= err_d;
				out_valid_q    <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign read_data    = read_data_q;
	assign access_error = access_error_q;
	assign irq_compare0 = icr_q[IC_IR0];
	assign irq_compare1 = icr_q[IC_IR1];

	`T64_ASSERT_NXT(a_count_only_on_tick, !(acc && req_type == REQ_TICK), $stable(count_q))
	`T64_ASSERT_NXT(a_ir0_needs_enable,
		acc && req_type == REQ_TICK && !icr_q[IC_EN0] && !icr_q[IC_IR0], !icr_q[IC_IR0])
	`T64_ASSERT_NXT(a_iscr_reads_zero,
		acc && req_type == REQ_READ && reg_index == REG_ISCR, read_data == 32'b0)
	`T64_ASSERT_NXT(a_err_only_on_write, acc && req_type != REQ_WRITE, !access_error)

endmodule
`default_nettype wire

[rtl/tmr64_window_cmp.sv]
// Masked window compare of the counter against one compare register.
`default_nettype none
module tmr64_window_cmp import tmr64_pkg::*; (
	input  logic [63:0] count,
	input  logic [31:0] cmp,
	input  window_cfg_t win,
	output logic        match
);

	logic [63:0] low_mask;
	logic [63:0] field;
	logic [63:0] want;

	// size+1 ones at the bottom, then moved up to the window start
	assign low_mask = ~(64'hFFFF_FFFF_FFFF_FFFE << win.size);
	assign field    = low_mask << win.start;
	assign want     = ({32'b0, cmp} << win.start) & field;
	assign match    = (count & field) == want;

endmodule
`default_nettype wire
